### src/pclru_pkg.sv
// Package for the page cache LRU lookup core: sizes, payload structs,
// controller command and status structs. No dependencies.
package pclru_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PAGE_W     = 32;
  localparam int SIZE_W     = 31;
  localparam int AGE_W      = 64;
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = 62;
  localparam int PROD_W     = PAGE_W + SIZE_W;

  localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = SIZE_W'(67108864);
  localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              fill_ok;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  slot_index;
    logic              fill_request;
    logic [ADDR_W-1:0] fill_address;
    logic              failed;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rsp_busy;
  } ctrl_status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

endpackage

### src/pclru_ctrl.sv
// Controller state machine for the page cache LRU lookup core.
// Depends on pclru_pkg for the state, command and status types.
module pclru_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic                    rsp_ready,
  input  pclru_pkg::ctrl_status_t status,
  output pclru_pkg::ctrl_cmd_t    cmd
);
  import pclru_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.rsp_busy || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/pclru_dp.sv
// Datapath for the page cache LRU lookup core: slot directory, access
// counter, page size register, scan trackers and result register.
// Depends on pclru_pkg.
module pclru_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  pclru_pkg::req_t         req_data,
  input  logic                    cfg_valid,
  input  logic [pclru_pkg::SIZE_W-1:0] cfg_data,
  input  logic                    rsp_ready,
  output logic                    rsp_valid,
  output pclru_pkg::rsp_t         rsp_data,
  input  pclru_pkg::ctrl_cmd_t    cmd,
  output pclru_pkg::ctrl_status_t status
);
  import pclru_pkg::*;

  logic [SIZE_W-1:0] page_size;
  logic [AGE_W-1:0]  access_count;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [PAGE_W-1:0] slot_page [NUM_SLOTS];
  logic [AGE_W-1:0]  slot_age  [NUM_SLOTS];

  logic [PAGE_W-1:0] page;
  logic              fill_ok;
  logic [ADDR_W-1:0] fill_address;
  logic [SLOT_W-1:0] scan_idx;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              best_set;
  logic [SLOT_W-1:0] best_idx;
  logic [AGE_W-1:0]  oldest_age;

  logic              cur_valid;
  logic [PAGE_W-1:0] cur_page;
  logic [AGE_W-1:0]  cur_age;
  logic [PROD_W-1:0] product;
  logic [SLOT_W-1:0] victim;
  logic [AGE_W-1:0]  count_inc;
  logic              do_update;
  logic [SLOT_W-1:0] upd_idx;

  assign cur_valid = slot_valid[scan_idx];
  assign cur_page  = slot_page[scan_idx];
  assign cur_age   = slot_age[scan_idx];
  assign product   = PROD_W'(req_data.page_number) * PROD_W'(page_size);
  assign victim    = free_found ? free_idx : best_idx;
  assign count_inc = access_count + AGE_W'(1);
  assign do_update = cmd.commit && (hit_found || fill_ok);
  assign upd_idx   = hit_found ? hit_idx : victim;

  assign status.scan_last = (scan_idx == LAST_SLOT);
  assign status.rsp_busy  = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PAGE_SIZE_RESET;
    end else if (cfg_valid) begin
      page_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page         <= req_data.page_number;
      fill_ok      <= req_data.fill_ok;
      fill_address <= product[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      hit_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      best_set   <= 1'b0;
      best_idx   <= '0;
      oldest_age <= '0;
    end else if (cmd.step) begin
      if (!status.scan_last) begin
        scan_idx <= scan_idx + SLOT_W'(1);
      end
      if (cur_valid && (cur_page == page) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
      if (cur_valid && (!best_set || (cur_age < oldest_age))) begin
        best_set   <= 1'b1;
        best_idx   <= scan_idx;
        oldest_age <= cur_age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      access_count <= '0;
    end else if (do_update) begin
      slot_valid[upd_idx] <= 1'b1;
      access_count        <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      slot_page[upd_idx] <= page;
      slot_age[upd_idx]  <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data.hit          <= hit_found;
      rsp_data.fill_request <= !hit_found;
      rsp_data.failed       <= !hit_found && !fill_ok;
      rsp_data.fill_address <= hit_found ? '0 : fill_address;
      if (hit_found) begin
        rsp_data.slot_index <= IDX_W'(hit_idx);
      end else if (fill_ok) begin
        rsp_data.slot_index <= IDX_W'(victim);
      end else begin
        rsp_data.slot_index <= '0;
      end
    end
  end

endmodule

### src/page_cache_lru_lookup_core.sv
// Page cache LRU lookup core: fully associative slot directory with
// timestamp LRU replacement.
// Requests come in on req_valid/req_ready with req_data (page_number,
// fill_ok). Results leave on rsp_valid/rsp_ready with rsp_data (hit,
// slot_index, fill_request, fill_address, failed), one per request.
// The page size register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, and writes belong to idle periods.
// Each request runs through a load step that takes it in and forms the
// page address product, a scan step per slot as the shared compare unit
// walks the directory for a hit, the first free slot and the oldest age,
// and a commit step that updates the directory and loads the result
// register. A new request is taken only after the last one has committed.
// The result register is separate from the scan, so the next request is
// taken while a result waits; if the receiver still stalls when that next
// scan ends, the block holds its finish step until the result register frees.
// Synchronous reset clears all valid bits and the access counter, empties the
// result register and sets the page size to 64 MiB.
// Depends on pclru_pkg, pclru_ctrl and pclru_dp.
module page_cache_lru_lookup_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  pclru_pkg::req_t              req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output pclru_pkg::rsp_t              rsp_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pclru_pkg::SIZE_W-1:0] cfg_data
);
  import pclru_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  pclru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pclru_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .status    (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a scan was starting");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.hit |-> !rsp_data.fill_request && !rsp_data.failed
      && (rsp_data.fill_address == '0))
    else $error("hit result carries fill fields");

  a_failed_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.failed |-> rsp_data.fill_request
      && (rsp_data.slot_index == '0))
    else $error("failed result malformed");

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rsp_valid || rsp_ready)
    else $error("result overwritten before transaction");

endmodule

### verif/page_cache_lru_lookup_core_tb.sv
// Testbench for page_cache_lru_lookup_core: directed and random page lookups
// checked against a behavioral copy of the LRU slot directory kept in this file.
// Depends on pclru_pkg and the core RTL.
module page_cache_lru_lookup_core_tb;
  import pclru_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * (NUM_SLOTS + 2) + 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 225;
  localparam int MAX_WORKING   = 16;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req_data  = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  page_cache_lru_lookup_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  req_t lookup_queue[$];
  rsp_t predicted_results[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic req_taken     = 1'b0;
  int   errors        = 0;
  int   cycle_count   = 0;
  int   hits          = 0;
  int   fills         = 0;
  int   failed_fills  = 0;
  int   size_writes   = 0;

  logic              dir_valid [NUM_SLOTS];
  logic [PAGE_W-1:0] dir_page  [NUM_SLOTS];
  logic [AGE_W-1:0]  dir_age   [NUM_SLOTS];
  logic [AGE_W-1:0]  dir_count;
  logic [SIZE_W-1:0] dir_page_size;

  logic [PAGE_W-1:0] working_set [MAX_WORKING];
  int                working_size;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rsp_t predict_lookup(req_t rq);
    rsp_t              r;
    int                hit_slot;
    int                victim;
    logic [PROD_W-1:0] product;
    r        = '0;
    hit_slot = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_slot < 0 && dir_valid[i] && dir_page[i] == rq.page_number) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      dir_count          = dir_count + AGE_W'(1);
      dir_age[hit_slot]  = dir_count;
      r.hit              = 1'b1;
      r.slot_index       = IDX_W'(hit_slot);
      return r;
    end
    victim = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (victim < 0 && !dir_valid[i]) victim = i;
    end
    if (victim < 0) begin
      victim = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (dir_age[i] < dir_age[victim]) victim = i;
      end
    end
    product        = PROD_W'(rq.page_number) * PROD_W'(dir_page_size);
    r.fill_request = 1'b1;
    r.fill_address = product[ADDR_W-1:0];
    if (!rq.fill_ok) begin
      r.failed = 1'b1;
      return r;
    end
    dir_count         = dir_count + AGE_W'(1);
    dir_valid[victim] = 1'b1;
    dir_page[victim]  = rq.page_number;
    dir_age[victim]   = dir_count;
    r.slot_index      = IDX_W'(victim);
    return r;
  endfunction

  function automatic int field_differs(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic void queue_lookup(logic [PAGE_W-1:0] page, logic ok);
    req_t rq;
    rq.page_number = page;
    rq.fill_ok     = ok;
    lookup_queue.push_back(rq);
  endfunction

  function automatic void queue_random_lookup();
    logic [PAGE_W-1:0] page;
    if ($urandom_range(99) < 82) page = working_set[$urandom_range(working_size - 1)];
    else page = $urandom();
    queue_lookup(page, $urandom_range(99) < 85);
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    int   bad;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("page_cache_lru_lookup_core: mismatch");
      $finish;
    end else begin
      req_taken = 1'b0;
      if (!rst) begin
        if (cfg_valid && cfg_ready) begin
          dir_page_size = cfg_data;
          size_writes++;
        end
        if (rsp_valid && rsp_ready) begin
          if (predicted_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual 0x%0h", $time, rsp_data);
            errors++;
          end else begin
            want = predicted_results.pop_front();
            bad  = field_differs("hit", 64'(want.hit), 64'(rsp_data.hit));
            bad += field_differs("slot_index", 64'(want.slot_index),
                                 64'(rsp_data.slot_index));
            bad += field_differs("fill_request", 64'(want.fill_request),
                                 64'(rsp_data.fill_request));
            bad += field_differs("fill_address", 64'(want.fill_address),
                                 64'(rsp_data.fill_address));
            bad += field_differs("failed", 64'(want.failed), 64'(rsp_data.failed));
            if (bad != 0) errors++;
            if (want.hit) hits++;
            else if (want.failed) failed_fills++;
            else fills++;
          end
        end
        if (req_valid && req_ready) begin
          predicted_results.push_back(predict_lookup(req_data));
          req_taken = 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    logic next_valid;
    req_t next_data;
    next_valid = req_valid;
    next_data  = req_data;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (req_taken) next_valid = 1'b0;
      if (!next_valid && lookup_queue.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_data  = lookup_queue.pop_front();
        next_valid = 1'b1;
      end
    end
    req_valid <= next_valid;
    req_data  <= next_data;
    rsp_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (lookup_queue.size() != 0 || req_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_page_size(logic [SIZE_W-1:0] size);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_size [RANDOM_PHASES];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      dir_valid[i] = 1'b0;
      dir_page[i]  = '0;
      dir_age[i]   = '0;
    end
    dir_count     = '0;
    dir_page_size = PAGE_SIZE_RESET;
    phase_size[0] = SIZE_W'(1);
    phase_size[1] = SIZE_W'(1073741824);
    phase_size[2] = {SIZE_W{1'b1}};
    phase_size[3] = '0;
    phase_size[4] = SIZE_W'($urandom_range(1073741824, 1));
    phase_size[5] = SIZE_W'($urandom_range(65536, 1));
    send_idle_pct = 29;
    recv_idle_pct = 88;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // fail on an empty directory, fill all slots, then exercise LRU eviction
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'h0000_0000, 1'b1);
    queue_lookup(32'h0000_0000, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b1);
    for (int p = 1; p <= 6; p++) queue_lookup(PAGE_W'(p), 1'b1);
    queue_lookup(32'h0000_0007, 1'b0);
    queue_lookup(32'h0000_0000, 1'b1);
    queue_lookup(32'h0000_0007, 1'b1);
    queue_lookup(32'hFFFF_FFFF, 1'b1);
    queue_lookup(32'h8000_0000, 1'b1);
    queue_lookup(32'h5555_5555, 1'b1);
    queue_lookup(32'hAAAA_AAAA, 1'b0);
    queue_lookup(32'hAAAA_AAAA, 1'b1);
    queue_lookup(32'h0000_0007, 1'b0);
    queue_lookup(32'hFFFF_FFFF, 1'b0);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 88;
        recv_idle_pct = 29;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_page_size(phase_size[phase]);
      working_size = $urandom_range(MAX_WORKING, NUM_SLOTS - 2);
      for (int i = 0; i < MAX_WORKING; i++) working_set[i] = $urandom();
      working_set[0] = (phase % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      repeat (PHASE_ITEMS) queue_random_lookup();
      settle();
    end

    $display("ran %0d lookups across %0d page sizes", hits + fills + failed_fills,
             size_writes + 1);
    $display("results: %0d hits, %0d fills, %0d failed fills, %0d errors",
             hits, fills, failed_fills, errors);
    if (errors == 0) begin
      $display("page_cache_lru_lookup_core: match");
    end else begin
      $display("page_cache_lru_lookup_core: mismatch");
    end
    $finish;
  end

endmodule
